// ----- hw/rtl/awd_pkg.sv -----
// shared constants and payload types for the area weighted rgba downscaler
`timescale 1ns / 1ps

package awd_pkg;

    localparam int MAX_SRC_DIM    = 4096;
    localparam int MAX_DST_WIDTH  = 1024;
    localparam int MAX_DST_HEIGHT = 1024;
    localparam int NUM_CH         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;
    localparam int SRC_DIM_W      = 13;
    localparam int DST_DIM_W      = 11;
    localparam int QUOT_W         = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_BGRA_ORDER = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] px_byte0;
        logic [7:0] px_byte1;
        logic [7:0] px_byte2;
        logic [7:0] px_byte3;
    } px_t;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
        logic [7:0] out_a;
        logic [9:0] out_col;
        logic [9:0] out_row;
        logic       frame_end;
    } res_t;

endpackage

// ----- hw/rtl/area_weighted_rgba_downscaler_top.sv -----
// top level: configuration registers, channel order and the two datapath units
// an item is accepted in the idle state, then each of its 1 to 4 accumulator updates runs
// issue, multiply and add in turn, a read-modify-write of the single-port accumulator memory
// a result's divide runs alongside the next items, and the result is held in a register
// until taken; after reset and after every write to a defined register index, a clearing
// pass zeroes the accumulator memory before pixels are taken
`timescale 1ns / 1ps

module area_weighted_rgba_downscaler_top #(
    parameter int MAX_SRC_DIM    = awd_pkg::MAX_SRC_DIM,
    parameter int MAX_DST_WIDTH  = awd_pkg::MAX_DST_WIDTH,
    parameter int MAX_DST_HEIGHT = awd_pkg::MAX_DST_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [awd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [awd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  awd_pkg::px_t                        pix,
    output logic                                res_valid,
    input  logic                                res_ready,
    output awd_pkg::res_t                       res
);

    localparam int SW_W   = $clog2(MAX_SRC_DIM + 1);
    localparam int AREA_W = 2 * SW_W;
    localparam int ACC_W  = 8 + 2 * $clog2(MAX_SRC_DIM);
    localparam int NCH    = awd_pkg::NUM_CH;

    logic [awd_pkg::SRC_DIM_W-1:0]  src_width_reg, src_height_reg;
    logic [awd_pkg::DST_DIM_W-1:0]  dst_width_reg, dst_height_reg;
    logic                           bgra_order_reg;
    logic                           cfg_hit;
    logic                           restart;

    logic [31:0]                    sw_c, sh_c, dw_c, dh_c;
    logic [SW_W-1:0]                sw_reg, sh_reg, dw_reg, dh_reg;
    logic [AREA_W-1:0]              area_reg;
    logic [NCH-1:0][7:0]            ch;

    logic                           div_valid, div_ready;
    logic [NCH-1:0][ACC_W-1:0]      div_sum;
    awd_pkg::res_t                  div_meta;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (cfg_index)
            awd_pkg::CFG_SRC_WIDTH,
            awd_pkg::CFG_SRC_HEIGHT,
            awd_pkg::CFG_DST_WIDTH,
            awd_pkg::CFG_DST_HEIGHT,
            awd_pkg::CFG_BGRA_ORDER: cfg_hit = 1'b1;
            default:                 cfg_hit = 1'b0;
        endcase
    end

    assign restart = cfg_valid && cfg_ready && cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= awd_pkg::SRC_DIM_W'(1);
            src_height_reg <= awd_pkg::SRC_DIM_W'(1);
            dst_width_reg  <= awd_pkg::DST_DIM_W'(1);
            dst_height_reg <= awd_pkg::DST_DIM_W'(1);
            bgra_order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                awd_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                awd_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                awd_pkg::CFG_DST_WIDTH:  dst_width_reg  <= awd_pkg::DST_DIM_W'(cfg_data);
                awd_pkg::CFG_DST_HEIGHT: dst_height_reg <= awd_pkg::DST_DIM_W'(cfg_data);
                awd_pkg::CFG_BGRA_ORDER: bgra_order_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // effective frame sizes
    always_comb
    begin
        sw_c = (src_width_reg == '0) ? 32'd1 : 32'(src_width_reg);
        if (sw_c > 32'(MAX_SRC_DIM))
        begin
            sw_c = 32'(MAX_SRC_DIM);
        end
        sh_c = (src_height_reg == '0) ? 32'd1 : 32'(src_height_reg);
        if (sh_c > 32'(MAX_SRC_DIM))
        begin
            sh_c = 32'(MAX_SRC_DIM);
        end
        dw_c = (dst_width_reg == '0) ? 32'd1 : 32'(dst_width_reg);
        if (dw_c > 32'(MAX_DST_WIDTH))
        begin
            dw_c = 32'(MAX_DST_WIDTH);
        end
        if (dw_c > sw_c)
        begin
            dw_c = sw_c;
        end
        dh_c = (dst_height_reg == '0) ? 32'd1 : 32'(dst_height_reg);
        if (dh_c > 32'(MAX_DST_HEIGHT))
        begin
            dh_c = 32'(MAX_DST_HEIGHT);
        end
        if (dh_c > sh_c)
        begin
            dh_c = sh_c;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_reg   <= SW_W'(sw_c);
        sh_reg   <= SW_W'(sh_c);
        dw_reg   <= SW_W'(dw_c);
        dh_reg   <= SW_W'(dh_c);
        area_reg <= AREA_W'(sw_reg) * AREA_W'(sh_reg);
    end

    always_comb
    begin
        ch[0] = bgra_order_reg ? pix.px_byte2 : pix.px_byte0;
        ch[1] = pix.px_byte1;
        ch[2] = bgra_order_reg ? pix.px_byte0 : pix.px_byte2;
        ch[3] = pix.px_byte3;
    end

    awd_acc #(
        .MAX_SRC_DIM    (MAX_SRC_DIM),
        .MAX_DST_WIDTH  (MAX_DST_WIDTH),
        .MAX_DST_HEIGHT (MAX_DST_HEIGHT)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .sw        (sw_reg),
        .sh        (sh_reg),
        .dw        (dw_reg),
        .dh        (dh_reg),
        .ch        (ch),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .div_ready (div_ready),
        .div_valid (div_valid),
        .div_sum   (div_sum),
        .div_meta  (div_meta)
    );

    awd_div #(
        .MAX_SRC_DIM (MAX_SRC_DIM)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .sum       (div_sum),
        .area      (area_reg),
        .meta      (div_meta),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ----- hw/rtl/awd_acc.sv -----
// position tracking, accumulator memory and read-modify-write sequencer
`timescale 1ns / 1ps

module awd_acc #(
    parameter int MAX_SRC_DIM    = awd_pkg::MAX_SRC_DIM,
    parameter int MAX_DST_WIDTH  = awd_pkg::MAX_DST_WIDTH,
    parameter int MAX_DST_HEIGHT = awd_pkg::MAX_DST_HEIGHT
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    restart,
    input  logic [$clog2(MAX_SRC_DIM+1)-1:0]                        sw,
    input  logic [$clog2(MAX_SRC_DIM+1)-1:0]                        sh,
    input  logic [$clog2(MAX_SRC_DIM+1)-1:0]                        dw,
    input  logic [$clog2(MAX_SRC_DIM+1)-1:0]                        dh,
    input  logic [awd_pkg::NUM_CH-1:0][7:0]                         ch,
    input  logic                                                    pix_valid,
    output logic                                                    pix_ready,
    input  logic                                                    div_ready,
    output logic                                                    div_valid,
    output logic [awd_pkg::NUM_CH-1:0][8+2*$clog2(MAX_SRC_DIM)-1:0] div_sum,
    output awd_pkg::res_t                                           div_meta
);

    localparam int SW_W   = $clog2(MAX_SRC_DIM + 1);
    localparam int XW     = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int YW     = (MAX_DST_HEIGHT > 1) ? $clog2(MAX_DST_HEIGHT) : 1;
    localparam int ACC_W  = 8 + 2 * $clog2(MAX_SRC_DIM);
    localparam int AW     = XW + 1;
    localparam int DEPTH  = 2 << XW;
    localparam int W_W    = 2 * SW_W;
    localparam int NCH    = awd_pkg::NUM_CH;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_MUL,
        S_ADD
    } state_t;

    state_t                        state_reg;
    logic [AW-1:0]                 clr_cnt_reg;
    logic [SW_W-1:0]               sx_reg, rx_reg, sy_reg, ry_reg;
    logic [XW-1:0]                 x0_reg;
    logic [YW-1:0]                 y0_reg;

    logic [NCH-1:0][7:0]           ch_reg;
    logic [3:0]                    tmask_reg;
    logic [SW_W-1:0]               wx0_reg, wx1_reg, wy0_reg, wy1_reg;
    logic [XW-1:0]                 xi_reg;
    logic [YW-1:0]                 yi_reg;
    logic                          emit_reg;
    logic                          fend_reg;
    logic [1:0]                    k_reg;

    logic [NCH-1:0][ACC_W-1:0]     mem [DEPTH];
    logic [NCH-1:0][ACC_W-1:0]     rd_reg;
    logic [W_W-1:0]                w_reg;
    logic [NCH-1:0][ACC_W-1:0]     prod_reg;

    logic [SW_W:0]                 sum_x, sum_y;
    logic                          col_done, row_done, xsplit, ysplit;
    logic [SW_W-1:0]               wx0_c, wx1_c, wy0_c, wy1_c;
    logic                          fend_c;
    logic                          accept;

    logic [XW-1:0]                 tcol;
    logic                          tbank;
    logic [SW_W-1:0]               twx, twy;
    logic [AW-1:0]                 taddr;
    logic [NCH-1:0][ACC_W-1:0]     sum_c;
    logic                          is_emit;
    logic                          more;
    logic [1:0]                    k_next;

    logic                          we_c;
    logic [AW-1:0]                 wa_c;
    logic [NCH-1:0][ACC_W-1:0]     wd_c;

    // span of the current source pixel over output columns and rows
    always_comb
    begin
        sum_x    = {1'b0, rx_reg} + {1'b0, dw};
        sum_y    = {1'b0, ry_reg} + {1'b0, dh};
        col_done = sum_x >= {1'b0, sw};
        row_done = sum_y >= {1'b0, sh};
        xsplit   = sum_x > {1'b0, sw};
        ysplit   = sum_y > {1'b0, sh};
        wx0_c    = xsplit ? (sw - rx_reg) : dw;
        wy0_c    = ysplit ? (sh - ry_reg) : dh;
        wx1_c    = SW_W'(sum_x - {1'b0, sw});
        wy1_c    = SW_W'(sum_y - {1'b0, sh});
        fend_c   = (32'(x0_reg) == 32'(dw) - 32'd1) && (32'(y0_reg) == 32'(dh) - 32'd1);
    end

    assign pix_ready = (state_reg == S_IDLE);
    assign accept    = pix_ready && pix_valid;

    // current update target
    always_comb
    begin
        tcol    = k_reg[0] ? (xi_reg + XW'(1)) : xi_reg;
        tbank   = k_reg[1] ? ~yi_reg[0] : yi_reg[0];
        twx     = k_reg[0] ? wx1_reg : wx0_reg;
        twy     = k_reg[1] ? wy1_reg : wy0_reg;
        taddr   = {tbank, tcol};
        is_emit = (k_reg == 2'd0) && emit_reg;
        for (int c = 0; c < NCH; c++)
        begin
            sum_c[c] = rd_reg[c] + prod_reg[c];
        end
        more   = 1'b0;
        k_next = k_reg;
        for (int i = 3; i >= 1; i--)
        begin
            if ((2'(i) > k_reg) && tmask_reg[i])
            begin
                more   = 1'b1;
                k_next = 2'(i);
            end
        end
    end

    assign div_valid = (state_reg == S_ADD) && is_emit;
    assign div_sum   = sum_c;

    always_comb
    begin
        div_meta           = '0;
        div_meta.out_col   = 10'(xi_reg);
        div_meta.out_row   = 10'(yi_reg);
        div_meta.frame_end = fend_reg;
    end

    // single write port: clearing pass or write-back
    always_comb
    begin
        we_c = 1'b0;
        wa_c = taddr;
        wd_c = sum_c;
        if (state_reg == S_CLEAR)
        begin
            we_c = 1'b1;
            wa_c = clr_cnt_reg;
            wd_c = '0;
        end
        else if (state_reg == S_ADD && (!is_emit || div_ready))
        begin
            we_c = 1'b1;
            if (is_emit)
            begin
                wd_c = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_c)
        begin
            mem[wa_c] <= wd_c;
        end
        if (state_reg == S_ISSUE)
        begin
            rd_reg <= mem[taddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg    <= ch;
            tmask_reg <= {xsplit & ysplit, ysplit, xsplit, 1'b1};
            wx0_reg   <= wx0_c;
            wx1_reg   <= wx1_c;
            wy0_reg   <= wy0_c;
            wy1_reg   <= wy1_c;
            xi_reg    <= x0_reg;
            yi_reg    <= y0_reg;
            emit_reg  <= col_done & row_done;
            fend_reg  <= fend_c;
        end
        if (state_reg == S_ISSUE)
        begin
            w_reg <= W_W'(twx) * W_W'(twy);
        end
        if (state_reg == S_MUL)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                prod_reg[c] <= ACC_W'((8 + W_W)'(ch_reg[c]) * (8 + W_W)'(w_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            k_reg       <= '0;
            sx_reg      <= '0;
            rx_reg      <= '0;
            x0_reg      <= '0;
            sy_reg      <= '0;
            ry_reg      <= '0;
            y0_reg      <= '0;
        end
        else if (restart)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            k_reg       <= '0;
            sx_reg      <= '0;
            rx_reg      <= '0;
            x0_reg      <= '0;
            sy_reg      <= '0;
            ry_reg      <= '0;
            y0_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pix_valid)
                    begin
                        state_reg <= S_ISSUE;
                        k_reg     <= '0;
                        if (sx_reg == sw - SW_W'(1))
                        begin
                            sx_reg <= '0;
                            rx_reg <= '0;
                            x0_reg <= '0;
                            if (sy_reg == sh - SW_W'(1))
                            begin
                                sy_reg <= '0;
                                ry_reg <= '0;
                                y0_reg <= '0;
                            end
                            else
                            begin
                                sy_reg <= sy_reg + SW_W'(1);
                                if (row_done)
                                begin
                                    ry_reg <= wy1_c;
                                    y0_reg <= y0_reg + YW'(1);
                                end
                                else
                                begin
                                    ry_reg <= SW_W'(sum_y);
                                end
                            end
                        end
                        else
                        begin
                            sx_reg <= sx_reg + SW_W'(1);
                            if (col_done)
                            begin
                                rx_reg <= wx1_c;
                                x0_reg <= x0_reg + XW'(1);
                            end
                            else
                            begin
                                rx_reg <= SW_W'(sum_x);
                            end
                        end
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (!is_emit || div_ready)
                    begin
                        if (more)
                        begin
                            k_reg     <= k_next;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/awd_div.sv -----
// four-channel iterative divider by the frame area with result register
`timescale 1ns / 1ps

module awd_div #(
    parameter int MAX_SRC_DIM = awd_pkg::MAX_SRC_DIM
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    in_valid,
    output logic                                                    in_ready,
    input  logic [awd_pkg::NUM_CH-1:0][8+2*$clog2(MAX_SRC_DIM)-1:0] sum,
    input  logic [2*$clog2(MAX_SRC_DIM+1)-1:0]                      area,
    input  awd_pkg::res_t                                           meta,
    output logic                                                    res_valid,
    input  logic                                                    res_ready,
    output awd_pkg::res_t                                           res
);

    localparam int ACC_W = 8 + 2 * $clog2(MAX_SRC_DIM);
    localparam int NCH   = awd_pkg::NUM_CH;
    localparam int QW    = awd_pkg::QUOT_W;
    localparam int STW   = $clog2(QW);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_HOLD
    } state_t;

    state_t                       state_reg;
    logic [STW-1:0]               step_reg;
    logic [NCH-1:0][ACC_W-1:0]    rem_reg;
    logic [ACC_W-1:0]             dv_reg;
    logic [NCH-1:0][QW-1:0]       q_reg;
    awd_pkg::res_t                meta_reg;

    assign in_ready  = (state_reg == D_IDLE);
    assign res_valid = (state_reg == D_HOLD);

    always_comb
    begin
        res       = meta_reg;
        res.out_r = q_reg[0];
        res.out_g = q_reg[1];
        res.out_b = q_reg[2];
        res.out_a = q_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= sum;
            dv_reg   <= ACC_W'(area) << (QW - 1);
            q_reg    <= '0;
            meta_reg <= meta;
        end
        else if (state_reg == D_RUN)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                if (rem_reg[c] >= dv_reg)
                begin
                    rem_reg[c] <= rem_reg[c] - dv_reg;
                    q_reg[c]   <= {q_reg[c][QW-2:0], 1'b1};
                end
                else
                begin
                    q_reg[c] <= {q_reg[c][QW-2:0], 1'b0};
                end
            end
            dv_reg <= dv_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= D_RUN;
                        step_reg  <= '1;
                    end
                end
                D_RUN:
                begin
                    step_reg <= step_reg - STW'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= D_HOLD;
                    end
                end
                D_HOLD:
                begin
                    if (res_ready)
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- verif/area_weighted_rgba_downscaler_top_test.sv -----
// self-checking testbench for the area weighted rgba downscaler top level
`timescale 1ns / 1ps

module area_weighted_rgba_downscaler_top_test;

    class downscale_scoreboard;
        longint unsigned acc_r[2*awd_pkg::MAX_DST_WIDTH];
        longint unsigned acc_g[2*awd_pkg::MAX_DST_WIDTH];
        longint unsigned acc_b[2*awd_pkg::MAX_DST_WIDTH];
        longint unsigned acc_a[2*awd_pkg::MAX_DST_WIDTH];
        longint unsigned chan[awd_pkg::NUM_CH];
        int unsigned     col_cnt;
        int unsigned     row_cnt;
        int unsigned     reg_sw;
        int unsigned     reg_sh;
        int unsigned     reg_dw;
        int unsigned     reg_dh;
        bit              reg_bgra;
        awd_pkg::res_t   expected_px[$];
        int              errors;
        int              pixels_in;
        int              pixels_out;
        int              frames_done;

        function new();
            reg_sw = 1;
            reg_sh = 1;
            reg_dw = 1;
            reg_dh = 1;
            reg_bgra = 0;
            errors = 0;
            pixels_in = 0;
            pixels_out = 0;
            frames_done = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (acc_r[i])
            begin
                acc_r[i] = 0;
                acc_g[i] = 0;
                acc_b[i] = 0;
                acc_a[i] = 0;
            end
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function longint unsigned clamp_dim(int unsigned v, longint unsigned hi);
            longint unsigned r;
            r = 64'(v);
            if (r == 0)
                r = 1;
            if (r > hi)
                r = hi;
            return r;
        endfunction

        function void write_reg(awd_pkg::cfg_idx_t idx,
                                logic [awd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                awd_pkg::CFG_SRC_WIDTH:  reg_sw = 32'(data);
                awd_pkg::CFG_SRC_HEIGHT: reg_sh = 32'(data);
                awd_pkg::CFG_DST_WIDTH:  reg_dw = 32'(data[awd_pkg::DST_DIM_W-1:0]);
                awd_pkg::CFG_DST_HEIGHT: reg_dh = 32'(data[awd_pkg::DST_DIM_W-1:0]);
                awd_pkg::CFG_BGRA_ORDER: reg_bgra = data[0];
                default: return;
            endcase
            restart_frame();
        endfunction

        function void add_weight(longint unsigned col, longint unsigned row,
                                 longint unsigned w);
            int unsigned idx;
            if (col >= awd_pkg::MAX_DST_WIDTH)
                return;
            idx = 32'((row & 1) * awd_pkg::MAX_DST_WIDTH + col);
            acc_r[idx] += chan[0] * w;
            acc_g[idx] += chan[1] * w;
            acc_b[idx] += chan[2] * w;
            acc_a[idx] += chan[3] * w;
        endfunction

        function void note_pixel(awd_pkg::px_t p);
            longint unsigned sw, sh, dw, dh, sx, sy, area;
            longint unsigned xbeg, xend, x0, x1, x0end, wx0, wx1;
            longint unsigned ybeg, yend, y0, y1, y0end, wy0, wy1;
            int unsigned idx;
            awd_pkg::res_t r;
            pixels_in++;
            sw = clamp_dim(reg_sw, awd_pkg::MAX_SRC_DIM);
            sh = clamp_dim(reg_sh, awd_pkg::MAX_SRC_DIM);
            dw = clamp_dim(reg_dw, awd_pkg::MAX_DST_WIDTH);
            dh = clamp_dim(reg_dh, awd_pkg::MAX_DST_HEIGHT);
            if (dw > sw)
                dw = sw;
            if (dh > sh)
                dh = sh;
            sx = (col_cnt >= sw) ? 0 : 64'(col_cnt);
            sy = (row_cnt >= sh) ? 0 : 64'(row_cnt);
            chan[0] = 64'(reg_bgra ? p.px_byte2 : p.px_byte0);
            chan[1] = 64'(p.px_byte1);
            chan[2] = 64'(reg_bgra ? p.px_byte0 : p.px_byte2);
            chan[3] = 64'(p.px_byte3);

            xbeg = sx * dw;
            xend = (sx + 1) * dw;
            x0 = xbeg / sw;
            x1 = (xend - 1) / sw;
            x0end = (x0 + 1) * sw;
            wx0 = ((xend < x0end) ? xend : x0end) - xbeg;
            wx1 = (x1 != x0) ? xend - x1 * sw : 0;
            ybeg = sy * dh;
            yend = (sy + 1) * dh;
            y0 = ybeg / sh;
            y1 = (yend - 1) / sh;
            y0end = (y0 + 1) * sh;
            wy0 = ((yend < y0end) ? yend : y0end) - ybeg;
            wy1 = (y1 != y0) ? yend - y1 * sh : 0;

            add_weight(x0, y0, wx0 * wy0);
            if (x1 != x0)
                add_weight(x1, y0, wx1 * wy0);
            if (y1 != y0)
            begin
                add_weight(x0, y1, wx0 * wy1);
                if (x1 != x0)
                    add_weight(x1, y1, wx1 * wy1);
            end

            if (x0end <= xend && y0end <= yend && x0 < awd_pkg::MAX_DST_WIDTH)
            begin
                idx = 32'((y0 & 1) * awd_pkg::MAX_DST_WIDTH + x0);
                area = sw * sh;
                r.out_r = 8'(acc_r[idx] / area);
                r.out_g = 8'(acc_g[idx] / area);
                r.out_b = 8'(acc_b[idx] / area);
                r.out_a = 8'(acc_a[idx] / area);
                r.out_col = 10'(x0);
                r.out_row = 10'(y0);
                r.frame_end = (x0 == dw - 1 && y0 == dh - 1);
                acc_r[idx] = 0;
                acc_g[idx] = 0;
                acc_b[idx] = 0;
                acc_a[idx] = 0;
                expected_px.push_back(r);
            end

            sx++;
            if (sx >= sw)
            begin
                sx = 0;
                sy++;
                if (sy >= sh)
                    sy = 0;
            end
            col_cnt = 32'(sx);
            row_cnt = 32'(sy);
        endfunction

        function void check_result(awd_pkg::res_t got);
            awd_pkg::res_t want;
            if (expected_px.size() == 0)
            begin
                $display("%0t: unexpected output pixel, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_px.pop_front();
            pixels_out++;
            if (got.frame_end && want.frame_end)
                frames_done++;
            if (got !== want)
            begin
                $display("%0t: output pixel mismatch, expected %p, actual %p",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 750;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [awd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [awd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           pix_valid;
    logic                           pix_ready;
    awd_pkg::px_t                   pix;
    logic                           res_valid;
    logic                           res_ready;
    awd_pkg::res_t                  res;

    downscale_scoreboard sb;
    bit                  calm;
    bit                  hold_req;
    bit                  timed_out;
    int                  idle_cycles;
    int                  phases;

    area_weighted_rgba_downscaler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function awd_pkg::px_t rand_pixel();
        awd_pkg::px_t p;
        p = awd_pkg::px_t'($urandom);
        if ($urandom_range(0, 9) == 0)
            p.px_byte0 = 8'hff;
        if ($urandom_range(0, 9) == 0)
            p.px_byte3 = 8'h00;
        return p;
    endfunction

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(awd_pkg::px_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix <= p;
        do
            @(posedge clk);
        while (!pix_ready);
        sb.note_pixel(p);
    endtask

    task automatic stop_pixels();
        pix_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only once the block has gone quiet
    task automatic write_reg(awd_pkg::cfg_idx_t idx, logic [awd_pkg::CFG_DATA_W-1:0] data);
        stop_pixels();
        wait_drained();
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(int sw, int sh, int dw, int dh, int bgra);
        write_reg(awd_pkg::CFG_SRC_WIDTH, awd_pkg::CFG_DATA_W'(sw));
        write_reg(awd_pkg::CFG_SRC_HEIGHT, awd_pkg::CFG_DATA_W'(sh));
        write_reg(awd_pkg::CFG_DST_WIDTH, awd_pkg::CFG_DATA_W'(dw));
        write_reg(awd_pkg::CFG_DST_HEIGHT, awd_pkg::CFG_DATA_W'(dh));
        write_reg(awd_pkg::CFG_BGRA_ORDER, awd_pkg::CFG_DATA_W'(bgra));
        phases++;
    endtask

    task automatic send_random(int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    task automatic rx_cycle(bit rdy);
        res_ready <= rdy;
        @(posedge clk);
        if (res_valid && res_ready)
            sb.check_result(res);
    endtask

    initial
    begin
        int r;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (400) rx_cycle(1'b0);
            end
            else if (calm)
                rx_cycle(1'b1);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    repeat ($urandom_range(1, 4)) rx_cycle(1'b0);
                else if (r < 12)
                    repeat ($urandom_range(20, 60)) rx_cycle(1'b0);
                else
                    rx_cycle(1'b1);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired at %0t with %0d output pixels outstanding",
                     $time, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int sw, sh, dw, dh, n;
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_valid = 1'b0;
        pix = '0;
        res_ready = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        timed_out = 1'b0;
        idle_cycles = 0;
        phases = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration is 1x1, so every pixel is a copy
        send_pixel('0);
        send_pixel('1);
        send_pixel(awd_pkg::px_t'(32'h12345678));
        write_reg(awd_pkg::CFG_BGRA_ORDER, awd_pkg::CFG_DATA_W'(1));
        send_pixel(awd_pkg::px_t'(32'hff00_80_01));
        send_pixel(awd_pkg::px_t'(32'h00ff_7ffe));

        // restart mid frame, then unknown register indexes that change nothing
        set_frame(4, 3, 2, 2, 0);
        send_random(5);
        write_reg(awd_pkg::cfg_idx_t'(3'd5), 13'h1fff);
        write_reg(awd_pkg::cfg_idx_t'(3'd6), 13'h0000);
        write_reg(awd_pkg::cfg_idx_t'(3'd7), 13'h0aaa);
        send_random(7);
        set_frame(3, 5, 2, 3, 1);
        send_random(4);
        write_reg(awd_pkg::CFG_DST_WIDTH, awd_pkg::CFG_DATA_W'(1));
        send_random(15);

        // zero and oversized sizes, and targets larger than the source
        set_frame(0, 0, 0, 0, 0);
        send_random(2);
        set_frame(3, 2, 2047, 1024, 8191);
        send_random(12);
        set_frame(8191, 0, 2047, 0, 0);
        send_random(200);
        set_frame(1, 5000, 1, 2047, 1);
        send_random(160);

        // copy mode with the receiver held off, so the block backs up
        set_frame(8, 8, 8, 8, 0);
        hold_req = 1'b1;
        send_random(64);

        // random frames, mostly well formed with some cut short
        while (sb.pixels_in < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            sw = $urandom_range(1, 16);
            sh = $urandom_range(1, 12);
            dw = $urandom_range(0, 3) == 0 ? sw : $urandom_range(1, sw + 4);
            dh = $urandom_range(0, 3) == 0 ? sh : $urandom_range(1, sh + 4);
            set_frame(sw, sh, dw, dh, $urandom_range(0, 8191));
            if ($urandom_range(0, 5) == 0)
                n = $urandom_range(1, sw * sh);
            else
                n = sw * sh * $urandom_range(1, 3);
            if (n > ITEM_TARGET + 10 - sb.pixels_in)
                n = ITEM_TARGET + 10 - sb.pixels_in;
            send_random(n);
        end
        calm = 1'b0;
        stop_pixels();
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d source pixels in %0d configurations, %0d output pixels checked",
                 sb.pixels_in, phases, sb.pixels_out);
        $display("%0d complete output frames seen, %0d mismatches", sb.frames_done, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
